// File: design/sprite_frame_time_selector_top_defines.svh
// Assertion macros shared by sfts_ctrl and sfts_dp
`ifndef SPRITE_FRAME_TIME_SELECTOR_TOP_DEFINES_SVH
`define SPRITE_FRAME_TIME_SELECTOR_TOP_DEFINES_SVH

`define SFTS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

`define SFTS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/sfts_pkg.sv
`default_nettype none
package sfts_pkg;
  localparam int unsigned Entries     = 16;
  localparam int unsigned GroupFrames = 32;
  localparam int unsigned Frames      = 1024;
  localparam int unsigned Groups      = 16;
  localparam int unsigned SlotW       = 9;
  localparam int unsigned SlotDepth   = 512;

  typedef enum logic [1:0] {
    MODE_SELECT = 2'd0,
    MODE_ENTRY  = 2'd1,
    MODE_GROUP  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_OVERRIDE  = 4'd0,
    ST_SINGLE    = 4'd1,
    ST_GROUP     = 4'd2,
    ST_WRITTEN   = 4'd3,
    ST_PENDING   = 4'd4,
    ST_BAD_TIME  = 4'd5,
    ST_BAD_CFG   = 4'd6,
    ST_BAD_ENTRY = 4'd7,
    ST_BAD_OVR   = 4'd8,
    ST_RANDOM    = 4'd9,
    ST_BAD_GROUP = 4'd10
  } status_e;

  typedef enum logic [1:0] {
    REG_MAX_ELAPSED = 2'd0,
    REG_RANDOM_SYNC = 2'd1,
    REG_ENTRY_COUNT = 2'd2,
    REG_FRAME_TOTAL = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_CHECK,
    FSM_SCAN,
    FSM_DIV,
    FSM_FIND,
    FSM_OUT
  } fsm_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  index;
    logic [4:0]  position;
    logic [31:0] time_value;
    logic [9:0]  frame_value;
    logic [5:0]  frame_count;
    logic        use_override;
    logic        entry_grouped;
    logic        has_group;
    logic [3:0]  group_number;
    logic        duration_positive;
    logic        profile_pending;
  } in_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [3:0]  entry_index;
    logic [9:0]  frame_index;
    logic        group_valid;
    logic [3:0]  group_out;
    logic        position_valid;
    logic [4:0]  group_position;
    logic [31:0] wrapped_time;
  } out_t;

  typedef struct packed {
    logic load;
    logic check;
    logic scan_step;
    logic div_start;
    logic div_step;
    logic find_step;
  } cmd_t;

  typedef struct packed {
    logic done_now;
    logic scan_last;
    logic scan_bad;
    logic div_last;
    logic find_hit;
    logic find_last;
  } sts_t;
endpackage
`default_nettype wire

// File: design/sfts_if.sv
`default_nettype none
interface sfts_in_if (input logic clk_i);
  logic            valid;
  logic            ready;
  sfts_pkg::in_t   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sfts_out_if (input logic clk_i);
  logic            valid;
  logic            ready;
  sfts_pkg::out_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/sfts_ram.sv
`default_nettype none
module sfts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: design/sfts_ctrl.sv
`default_nettype none
`include "sprite_frame_time_selector_top_defines.svh"
module sfts_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire sfts_pkg::sts_t sts_i,
  output sfts_pkg::cmd_t      cmd_o
);
  sfts_pkg::fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfts_pkg::FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sfts_pkg::FSM_IDLE:  if (in_valid_i) state_d = sfts_pkg::FSM_CHECK;
      sfts_pkg::FSM_CHECK: state_d = sts_i.done_now ? sfts_pkg::FSM_OUT : sfts_pkg::FSM_SCAN;
      sfts_pkg::FSM_SCAN: begin
        if (sts_i.scan_bad) state_d = sfts_pkg::FSM_OUT;
        else if (sts_i.scan_last) state_d = sfts_pkg::FSM_DIV;
      end
      sfts_pkg::FSM_DIV:   if (sts_i.div_last) state_d = sfts_pkg::FSM_FIND;
      sfts_pkg::FSM_FIND:  if (sts_i.find_hit || sts_i.find_last) state_d = sfts_pkg::FSM_OUT;
      sfts_pkg::FSM_OUT:   if (out_ready_i) state_d = sfts_pkg::FSM_IDLE;
      default:             state_d = sfts_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      sfts_pkg::FSM_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      sfts_pkg::FSM_CHECK: begin
        cmd_o.check = 1'b1;
      end
      sfts_pkg::FSM_SCAN: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.div_start = sts_i.scan_last && !sts_i.scan_bad;
      end
      sfts_pkg::FSM_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      sfts_pkg::FSM_FIND: cmd_o.find_step = 1'b1;
      sfts_pkg::FSM_OUT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

  `SFTS_ASSERT_IMP(a_excl, clk_i, rst_ni, 1'b1, !(in_ready_o && out_valid_o))
  `SFTS_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `SFTS_ASSERT_NXT(a_load, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
endmodule
`default_nettype wire

// File: design/sfts_dp.sv
`default_nettype none
`include "sprite_frame_time_selector_top_defines.svh"
module sfts_dp (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [1:0]     cfg_idx_i,
  input  wire logic [31:0]    cfg_data_i,
  input  wire sfts_pkg::in_t  in_i,
  input  wire sfts_pkg::cmd_t cmd_i,
  output sfts_pkg::sts_t      sts_o,
  output sfts_pkg::out_t      out_o
);
  logic [31:0] max_q;
  logic        rsync_q;
  logic [4:0]  ecnt_q;
  logic [10:0] ftot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= 32'd235929600;
      rsync_q <= 1'b0;
      ecnt_q  <= '0;
      ftot_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (sfts_pkg::reg_e'(cfg_idx_i))
        sfts_pkg::REG_MAX_ELAPSED: max_q   <= cfg_data_i;
        sfts_pkg::REG_RANDOM_SYNC: rsync_q <= cfg_data_i[0];
        sfts_pkg::REG_ENTRY_COUNT: ecnt_q  <= cfg_data_i[4:0];
        sfts_pkg::REG_FRAME_TOTAL: ftot_q  <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  sfts_pkg::in_t in_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) in_q <= in_i;
  end

  logic [9:0] e_first_q [sfts_pkg::Entries];
  logic [5:0] e_len_q   [sfts_pkg::Entries];
  logic       e_grp_q   [sfts_pkg::Entries];
  logic       e_hasg_q  [sfts_pkg::Entries];
  logic [3:0] e_g_q     [sfts_pkg::Entries];
  logic [5:0] g_len_q   [sfts_pkg::Groups];

  logic wr_entry, wr_group;
  assign wr_entry = cmd_i.check && (in_q.mode == sfts_pkg::MODE_ENTRY);
  assign wr_group = cmd_i.check && (in_q.mode == sfts_pkg::MODE_GROUP);

  always_ff @(posedge clk_i) begin
    if (wr_entry) begin
      e_first_q[in_q.index] <= in_q.frame_value;
      e_len_q[in_q.index]   <= in_q.frame_count;
      e_grp_q[in_q.index]   <= in_q.entry_grouped;
      e_hasg_q[in_q.index]  <= in_q.has_group;
      e_g_q[in_q.index]     <= in_q.group_number;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sfts_pkg::Groups; i++) g_len_q[i] <= '0;
    end else if (wr_group) begin
      g_len_q[in_q.index] <= in_q.frame_count;
    end
  end

  logic [sfts_pkg::SlotW-1:0] waddr, raddr;
  logic [42:0] rdata;
  logic [4:0]  k_q;
  logic [3:0]  g_q;
  assign waddr = {in_q.index, in_q.position};
  assign raddr = {g_q, k_q};

  sfts_ram #(.Width(43), .Depth(sfts_pkg::SlotDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_group),
    .waddr_i(waddr),
    .wdata_i({in_q.duration_positive, in_q.frame_value, in_q.time_value}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  logic [9:0]  first;
  logic [5:0]  len;
  logic [10:0] endf;
  logic [5:0]  cnt;
  logic [3:0]  gsel;
  assign first = e_first_q[in_q.index];
  assign len   = e_len_q[in_q.index];
  assign endf  = {1'b0, first} + {5'd0, len};
  assign gsel  = e_g_q[in_q.index];
  assign cnt   = g_len_q[gsel];

  sfts_pkg::status_e st;
  always_comb begin
    priority if (in_q.mode == sfts_pkg::MODE_ENTRY || in_q.mode == sfts_pkg::MODE_GROUP)
      st = sfts_pkg::ST_WRITTEN;
    else if (in_q.mode == sfts_pkg::MODE_NONE) st = sfts_pkg::ST_BAD_CFG;
    else if (max_q == '0) st = sfts_pkg::ST_BAD_CFG;
    else if (in_q.profile_pending) st = sfts_pkg::ST_PENDING;
    else if (in_q.time_value > max_q) st = sfts_pkg::ST_BAD_TIME;
    else if (ecnt_q > 5'(sfts_pkg::Entries) || ftot_q > 11'(sfts_pkg::Frames))
      st = sfts_pkg::ST_BAD_CFG;
    else if ({1'b0, in_q.index} >= ecnt_q) st = sfts_pkg::ST_BAD_ENTRY;
    else if (len == '0 || endf > ftot_q) st = sfts_pkg::ST_BAD_ENTRY;
    else if (in_q.use_override) begin
      if (in_q.frame_value < first || {1'b0, in_q.frame_value} >= endf)
        st = sfts_pkg::ST_BAD_OVR;
      else st = sfts_pkg::ST_OVERRIDE;
    end else if (!e_grp_q[in_q.index]) begin
      if (len != 6'd1 || e_hasg_q[in_q.index]) st = sfts_pkg::ST_BAD_ENTRY;
      else st = sfts_pkg::ST_SINGLE;
    end else if (rsync_q) st = sfts_pkg::ST_RANDOM;
    else if (!e_hasg_q[in_q.index]) st = sfts_pkg::ST_BAD_GROUP;
    else if (cnt == '0 || cnt > 6'(sfts_pkg::GroupFrames) || cnt != len)
      st = sfts_pkg::ST_BAD_GROUP;
    else st = sfts_pkg::ST_GROUP;
  end
  assign sts_o.done_now = (st != sfts_pkg::ST_GROUP);

  // scan: RAM read data of slot k arrives in the cycle after k is presented
  logic        rd_ok_q;
  logic [5:0]  kd_q;
  logic [31:0] prev_q;
  logic [31:0] r_end;
  logic [9:0]  r_frame;
  logic        r_ok;
  assign r_end   = rdata[31:0];
  assign r_frame = rdata[41:32];
  assign r_ok    = rdata[42];

  logic scan_fail;
  assign scan_fail = rd_ok_q && (r_frame < first || {1'b0, r_frame} >= endf || !r_ok
                                 || r_end <= prev_q);
  assign sts_o.scan_bad  = cmd_i.scan_step && scan_fail;
  assign sts_o.scan_last = rd_ok_q && (kd_q == cnt - 6'd1);

  // restoring divider
  logic [31:0] rem_q, quo_q;
  logic [5:0]  dcnt_q;
  logic [32:0] trial;
  assign trial = {rem_q, quo_q[31]} - {1'b0, prev_q};
  assign sts_o.div_last = (dcnt_q == 6'd31);

  assign sts_o.find_hit  = rd_ok_q && (r_end > rem_q);
  assign sts_o.find_last = rd_ok_q && (kd_q == cnt - 6'd1);

  sfts_pkg::out_t res_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      g_q     <= gsel;
      k_q     <= '0;
      rd_ok_q <= 1'b0;
      prev_q  <= '0;
      res_q   <= '0;
      res_q.status      <= st;
      res_q.entry_index <= in_q.index;
      if (st == sfts_pkg::ST_OVERRIDE) begin
        res_q.frame_index  <= in_q.frame_value;
        res_q.group_valid  <= e_hasg_q[in_q.index];
        res_q.group_out    <= e_hasg_q[in_q.index] ? gsel : 4'd0;
        res_q.wrapped_time <= in_q.time_value;
      end else if (st == sfts_pkg::ST_SINGLE) begin
        res_q.frame_index <= first;
      end
    end
    if (cmd_i.scan_step) begin
      k_q     <= k_q + 5'd1;
      rd_ok_q <= 1'b1;
      kd_q    <= {1'b0, k_q};
      if (rd_ok_q) prev_q <= r_end;
      if (scan_fail) begin
        res_q <= '0;
        res_q.status      <= sfts_pkg::ST_BAD_GROUP;
        res_q.entry_index <= in_q.index;
      end
    end
    if (cmd_i.div_start) begin
      prev_q <= r_end;
      rem_q  <= '0;
      quo_q  <= in_q.time_value;
      dcnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + 6'd1;
      quo_q  <= {quo_q[30:0], !trial[32]};
      rem_q  <= trial[32] ? {rem_q[30:0], quo_q[31]} : trial[31:0];
      k_q     <= '0;
      rd_ok_q <= 1'b0;
    end
    if (cmd_i.find_step) begin
      k_q     <= k_q + 5'd1;
      rd_ok_q <= 1'b1;
      kd_q    <= {1'b0, k_q};
      if (sts_o.find_hit) begin
        res_q.status         <= sfts_pkg::ST_GROUP;
        res_q.frame_index    <= r_frame;
        res_q.group_valid    <= 1'b1;
        res_q.group_out      <= g_q;
        res_q.position_valid <= 1'b1;
        res_q.group_position <= kd_q[4:0];
        res_q.wrapped_time   <= rem_q;
      end else if (sts_o.find_last) begin
        res_q <= '0;
        res_q.status      <= sfts_pkg::ST_BAD_GROUP;
        res_q.entry_index <= in_q.index;
      end
    end
  end
  assign out_o = res_q;

  `SFTS_ASSERT_IMP(a_div, clk_i, rst_ni, cmd_i.div_step, prev_q != '0)
  `SFTS_ASSERT_IMP(a_one, clk_i, rst_ni, 1'b1,
    $onehot0({cmd_i.check, cmd_i.scan_step, cmd_i.div_step, cmd_i.find_step}))
  `SFTS_ASSERT_NXT(a_wr, clk_i, rst_ni, wr_group || wr_entry, out_o.status == sfts_pkg::ST_WRITTEN)
endmodule
`default_nettype wire

// File: design/sprite_frame_time_selector_top.sv
// channel | dir | payload
// in_ch   | in  | sfts_pkg::in_t (mode, index, times, frames, flags)
// out_ch  | out | sfts_pkg::out_t (status, frame, group, position, wrapped time)
// cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i
// One item at a time. Writes and early results go straight from check to output.
// A grouped select walks the group slot RAM, runs a restoring divider, then
// walks it again to find the slot that holds the wrapped time.
// Reset clears control, group lengths, config except max elapsed; tables unset.
// A stalled result holds in its register; no new item is taken until it leaves.
`default_nettype none
module sprite_frame_time_selector_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  sfts_in_if.sink          in_ch,
  sfts_out_if.source       out_ch
);
  sfts_pkg::cmd_t cmd;
  sfts_pkg::sts_t sts;

  sfts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .out_valid_o(out_ch.valid),
    .out_ready_i(out_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sfts_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_ch.data),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_o     (out_ch.data)
  );
endmodule
`default_nettype wire

// File: dv/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  class frame_scoreboard;
    logic [31:0]     max_el;
    bit              rsync;
    bit [4:0]        ecount;
    bit [10:0]       ftotal;
    bit [9:0]        e_first[sfts_pkg::Entries];
    bit [5:0]        e_len[sfts_pkg::Entries];
    bit              e_grp[sfts_pkg::Entries];
    bit              e_hasg[sfts_pkg::Entries];
    bit [3:0]        e_g[sfts_pkg::Entries];
    bit              e_set[sfts_pkg::Entries];
    bit [5:0]        g_len[sfts_pkg::Groups];
    bit [31:0]       g_end[sfts_pkg::SlotDepth];
    bit [9:0]        g_frm[sfts_pkg::SlotDepth];
    bit              g_dok[sfts_pkg::SlotDepth];
    bit              g_set[sfts_pkg::SlotDepth];
    sfts_pkg::out_t  expq[$];
    int              errors;
    int              n_results;
    int              n_grouped;

    function new();
      max_el = 32'd235929600;
      rsync = 0;
      ecount = 0;
      ftotal = 0;
      errors = 0;
      n_results = 0;
      n_grouped = 0;
      foreach (g_len[i]) g_len[i] = 0;
      foreach (e_set[i]) e_set[i] = 0;
      foreach (g_set[i]) g_set[i] = 0;
    endfunction

    function void set_reg(sfts_pkg::reg_e r, logic [31:0] v);
      case (r)
        sfts_pkg::REG_MAX_ELAPSED: max_el = v;
        sfts_pkg::REG_RANDOM_SYNC: rsync = v[0];
        sfts_pkg::REG_ENTRY_COUNT: ecount = v[4:0];
        default:                   ftotal = v[10:0];
      endcase
    endfunction

    function bit early_exit(sfts_pkg::in_t it);
      return max_el == 0 || it.profile_pending || it.time_value > max_el ||
             32'(ecount) > sfts_pkg::Entries || 32'(ftotal) > sfts_pkg::Frames ||
             {1'b0, it.index} >= ecount;
    endfunction

    function bit touches_unset(sfts_pkg::in_t it);
      int unsigned first, len, cnt, base;
      if (sfts_pkg::mode_e'(it.mode) != sfts_pkg::MODE_SELECT || early_exit(it)) return 0;
      if (!e_set[it.index]) return 1;
      first = 32'(e_first[it.index]);
      len = 32'(e_len[it.index]);
      if (len == 0 || first + len > 32'(ftotal) || it.use_override) return 0;
      if (!e_grp[it.index] || rsync || !e_hasg[it.index]) return 0;
      cnt = 32'(g_len[e_g[it.index]]);
      if (cnt == 0 || cnt > sfts_pkg::GroupFrames || cnt != len) return 0;
      base = 32'(e_g[it.index]) * sfts_pkg::GroupFrames;
      for (int unsigned k = 0; k < cnt; k++) if (!g_set[base + k]) return 1;
      return 0;
    endfunction

    function sfts_pkg::out_t select_frame(sfts_pkg::in_t it);
      sfts_pkg::out_t r;
      int unsigned first, len, lim, g, cnt, base, prev, wr, k;
      r = '0;
      r.entry_index = it.index;
      r.status = sfts_pkg::ST_BAD_CFG;
      if (max_el == 0) return r;
      r.status = sfts_pkg::ST_PENDING;
      if (it.profile_pending) return r;
      r.status = sfts_pkg::ST_BAD_TIME;
      if (it.time_value > max_el) return r;
      r.status = sfts_pkg::ST_BAD_CFG;
      if (32'(ecount) > sfts_pkg::Entries || 32'(ftotal) > sfts_pkg::Frames) return r;
      r.status = sfts_pkg::ST_BAD_ENTRY;
      if ({1'b0, it.index} >= ecount) return r;
      first = 32'(e_first[it.index]);
      len = 32'(e_len[it.index]);
      lim = first + len;
      if (len == 0 || lim > 32'(ftotal)) return r;
      if (it.use_override) begin
        r.status = sfts_pkg::ST_BAD_OVR;
        if (32'(it.frame_value) < first || 32'(it.frame_value) >= lim) return r;
        r.status = sfts_pkg::ST_OVERRIDE;
        r.frame_index = it.frame_value;
        r.group_valid = e_hasg[it.index];
        r.group_out = e_hasg[it.index] ? e_g[it.index] : 4'd0;
        r.wrapped_time = it.time_value;
        return r;
      end
      if (!e_grp[it.index]) begin
        if (len != 1 || e_hasg[it.index]) return r;
        r.status = sfts_pkg::ST_SINGLE;
        r.frame_index = e_first[it.index];
        return r;
      end
      r.status = sfts_pkg::ST_RANDOM;
      if (rsync) return r;
      r.status = sfts_pkg::ST_BAD_GROUP;
      g = 32'(e_g[it.index]);
      if (!e_hasg[it.index]) return r;
      cnt = 32'(g_len[g]);
      if (cnt == 0 || cnt > sfts_pkg::GroupFrames || cnt != len) return r;
      base = g * sfts_pkg::GroupFrames;
      prev = 0;
      for (k = 0; k < cnt; k++) begin
        if (32'(g_frm[base + k]) < first || 32'(g_frm[base + k]) >= lim ||
            !g_dok[base + k] || g_end[base + k] <= prev) return r;
        prev = g_end[base + k];
      end
      wr = it.time_value % prev;
      for (k = 0; k < cnt; k++) if (g_end[base + k] > wr) break;
      if (k >= cnt) return r;
      r.status = sfts_pkg::ST_GROUP;
      r.frame_index = g_frm[base + k];
      r.group_valid = 1;
      r.group_out = 4'(g);
      r.position_valid = 1;
      r.group_position = 5'(k);
      r.wrapped_time = wr;
      return r;
    endfunction

    function void note_input(sfts_pkg::in_t it);
      sfts_pkg::out_t r;
      int unsigned slot;
      r = '0;
      r.entry_index = it.index;
      r.status = sfts_pkg::ST_WRITTEN;
      case (sfts_pkg::mode_e'(it.mode))
        sfts_pkg::MODE_SELECT: r = select_frame(it);
        sfts_pkg::MODE_ENTRY: begin
          e_first[it.index] = it.frame_value;
          e_len[it.index] = it.frame_count;
          e_grp[it.index] = it.entry_grouped;
          e_hasg[it.index] = it.has_group;
          e_g[it.index] = it.group_number;
          e_set[it.index] = 1;
        end
        sfts_pkg::MODE_GROUP: begin
          slot = 32'(it.index) * sfts_pkg::GroupFrames + 32'(it.position);
          g_len[it.index] = it.frame_count;
          g_end[slot] = it.time_value;
          g_frm[slot] = it.frame_value;
          g_dok[slot] = it.duration_positive;
          g_set[slot] = 1;
        end
        default: r.status = sfts_pkg::ST_BAD_CFG;
      endcase
      expq.push_back(r);
    endfunction

    function bit field_ok(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $display("%0t: mismatch %s expected %0h actual %0h", $time, name, e, a);
        return 0;
      end
      return 1;
    endfunction

    function void check_result(sfts_pkg::out_t got);
      sfts_pkg::out_t e;
      bit ok;
      n_results++;
      if (expq.size() == 0) begin
        $display("%0t: unexpected result expected none actual %p", $time, got);
        errors++;
        return;
      end
      e = expq.pop_front();
      if (got.status === sfts_pkg::ST_GROUP) n_grouped++;
      ok = field_ok("status", 32'(e.status), 32'(got.status));
      ok &= field_ok("entry_index", 32'(e.entry_index), 32'(got.entry_index));
      ok &= field_ok("frame_index", 32'(e.frame_index), 32'(got.frame_index));
      ok &= field_ok("group_valid", 32'(e.group_valid), 32'(got.group_valid));
      ok &= field_ok("group_out", 32'(e.group_out), 32'(got.group_out));
      ok &= field_ok("position_valid", 32'(e.position_valid), 32'(got.position_valid));
      ok &= field_ok("group_position", 32'(e.group_position), 32'(got.group_position));
      ok &= field_ok("wrapped_time", e.wrapped_time, got.wrapped_time);
      if (!ok) errors++;
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  int          n_items;

  sfts_in_if  in_ch (clk_i);
  sfts_out_if out_ch (clk_i);
  frame_scoreboard sb;

  sprite_frame_time_selector_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic sfts_pkg::in_t rand_item();
    sfts_pkg::in_t it;
    it.mode = 2'($urandom);
    it.index = 4'($urandom);
    it.position = 5'($urandom);
    it.time_value = $urandom;
    it.frame_value = 10'($urandom);
    it.frame_count = 6'($urandom);
    it.use_override = 1'($urandom);
    it.entry_grouped = 1'($urandom);
    it.has_group = 1'($urandom);
    it.group_number = 4'($urandom);
    it.duration_positive = 1'($urandom);
    it.profile_pending = 1'($urandom);
    return it;
  endfunction

  function automatic sfts_pkg::in_t mk(sfts_pkg::mode_e m, int idx, int pos, logic [31:0] t,
                                       int fv, int fc, bit ovr, bit grp, bit hasg, int gn,
                                       bit dur, bit pend);
    sfts_pkg::in_t it;
    it.mode = m;
    it.index = 4'(idx);
    it.position = 5'(pos);
    it.time_value = t;
    it.frame_value = 10'(fv);
    it.frame_count = 6'(fc);
    it.use_override = ovr;
    it.entry_grouped = grp;
    it.has_group = hasg;
    it.group_number = 4'(gn);
    it.duration_positive = dur;
    it.profile_pending = pend;
    return it;
  endfunction

  task automatic send_item(sfts_pkg::in_t it);
    int gap;
    gap = int'($urandom_range(0, 5));
    if (sb.touches_unset(it)) it.profile_pending = 1'b1;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_input(it);
    n_items++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.expq.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic cfg_write(sfts_pkg::reg_e r, logic [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= r;
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.set_reg(r, v);
  endtask

  task automatic configure(logic [31:0] me, bit rs, logic [4:0] ec, logic [10:0] ft);
    cfg_write(sfts_pkg::REG_MAX_ELAPSED, me);
    cfg_write(sfts_pkg::REG_RANDOM_SYNC, {31'd0, rs});
    cfg_write(sfts_pkg::REG_ENTRY_COUNT, {27'd0, ec});
    cfg_write(sfts_pkg::REG_FRAME_TOTAL, {21'd0, ft});
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_group_sequence();
    sfts_pkg::in_t it;
    int g, len, first, ent, brk, nsel;
    logic [31:0] tend, prev, step;
    g = int'($urandom_range(0, 15));
    len = ($urandom_range(0, 9) == 0) ? 32 : int'($urandom_range(1, 6));
    first = int'($urandom_range(0, 1024 - len));
    ent = int'($urandom_range(0, 15));
    brk = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, len - 1)) : -1;
    tend = 0;
    for (int p = 0; p < len; p++) begin
      prev = tend;
      step = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 262144) : $urandom_range(1, 200);
      tend = tend + step;
      it = rand_item();
      it.mode = sfts_pkg::MODE_GROUP;
      it.index = 4'(g);
      it.position = 5'(p);
      it.time_value = tend;
      it.frame_value = 10'(first + int'($urandom_range(0, len - 1)));
      it.frame_count = 6'(len);
      it.duration_positive = 1'b1;
      if (p == brk) begin
        case ($urandom_range(0, 2))
          0: it.duration_positive = 1'b0;
          1: it.time_value = prev;
          default: it.frame_value = 10'(first + len);
        endcase
      end
      send_item(it);
    end
    it = rand_item();
    it.mode = sfts_pkg::MODE_ENTRY;
    it.index = 4'(ent);
    it.frame_value = 10'(first);
    it.frame_count = 6'(($urandom_range(0, 9) == 0) ? len + 1 : len);
    it.entry_grouped = 1'b1;
    it.has_group = 1'b1;
    it.group_number = 4'(g);
    send_item(it);
    nsel = int'($urandom_range(3, 8));
    repeat (nsel) begin
      it = rand_item();
      it.mode = sfts_pkg::MODE_SELECT;
      it.index = 4'(ent);
      it.use_override = ($urandom_range(0, 5) == 0);
      it.frame_value = 10'(first + int'($urandom_range(0, len + 1)) - 1);
      it.profile_pending = ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 3))
        0: it.time_value = $urandom_range(0, 4 * tend);
        1: it.time_value = $urandom;
        2: it.time_value = tend * $urandom_range(0, 50);
        default: it.time_value = tend * $urandom_range(1, 50) - 32'd1;
      endcase
      send_item(it);
    end
  endtask

  task automatic run_single_sequence();
    sfts_pkg::in_t it;
    int ent;
    ent = int'($urandom_range(0, 15));
    it = rand_item();
    it.mode = sfts_pkg::MODE_ENTRY;
    it.index = 4'(ent);
    it.frame_count = 6'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 1);
    it.entry_grouped = ($urandom_range(0, 5) == 0);
    it.has_group = ($urandom_range(0, 4) == 0);
    send_item(it);
    repeat (2) begin
      it = rand_item();
      it.mode = sfts_pkg::MODE_SELECT;
      it.index = 4'(ent);
      it.use_override = ($urandom_range(0, 3) == 0);
      it.profile_pending = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 1) != 0) it.time_value = $urandom_range(0, 1000000);
      send_item(it);
    end
  endtask

  task automatic run_directed();
    send_item(mk(sfts_pkg::MODE_ENTRY, 0, 0, 0, 1023, 1, 0, 0, 0, 0, 0, 0));
    send_item(mk(sfts_pkg::MODE_SELECT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(sfts_pkg::MODE_GROUP, 15, 0, 32'h0001_0000, 5, 3, 0, 0, 0, 0, 1, 0));
    send_item(mk(sfts_pkg::MODE_GROUP, 15, 1, 32'h0002_0000, 6, 3, 0, 0, 0, 0, 1, 0));
    send_item(mk(sfts_pkg::MODE_GROUP, 15, 2, 32'hFFFF_FFFF, 7, 3, 0, 0, 0, 0, 1, 0));
    send_item(mk(sfts_pkg::MODE_ENTRY, 1, 0, 0, 5, 3, 0, 1, 1, 15, 0, 0));
    send_item(mk(sfts_pkg::MODE_SELECT, 1, 0, 32'h0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(sfts_pkg::MODE_SELECT, 1, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(sfts_pkg::MODE_SELECT, 1, 0, 32'h0001_8000, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(sfts_pkg::MODE_SELECT, 1, 0, 32'h0001_0000, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(sfts_pkg::MODE_SELECT, 1, 0, 32'h1234, 6, 0, 1, 0, 0, 0, 0, 0));
    send_item(mk(sfts_pkg::MODE_SELECT, 1, 0, 32'h1234, 8, 0, 1, 0, 0, 0, 0, 0));
    send_item(mk(sfts_pkg::MODE_SELECT, 1, 0, 32'h1234, 4, 0, 1, 0, 0, 0, 0, 0));
    send_item(mk(sfts_pkg::MODE_SELECT, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    send_item(mk(sfts_pkg::MODE_NONE, 15, 31, 32'hFFFF_FFFF, 1023, 63, 1, 1, 1, 15, 1, 1));
    send_item(mk(sfts_pkg::MODE_ENTRY, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(sfts_pkg::MODE_SELECT, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(sfts_pkg::MODE_ENTRY, 3, 0, 0, 0, 2, 0, 0, 0, 0, 0, 0));
    send_item(mk(sfts_pkg::MODE_SELECT, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(sfts_pkg::MODE_GROUP, 0, 31, 32'hFFFF_FFFF, 1023, 63, 1, 1, 1, 15, 0, 1));
    send_item(mk(sfts_pkg::MODE_ENTRY, 4, 0, 0, 0, 63, 0, 1, 1, 0, 0, 0));
    send_item(mk(sfts_pkg::MODE_SELECT, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(sfts_pkg::MODE_ENTRY, 5, 0, 0, 5, 3, 0, 1, 0, 15, 0, 0));
    send_item(mk(sfts_pkg::MODE_SELECT, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  initial begin
    sfts_pkg::out_t got;
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = int'($urandom_range(0, 5));
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      got = out_ch.data;
      sb.check_result(got);
    end
  end

  initial begin
    #30ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int start;
    int pick;
    sb = new();
    n_items = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: configure(32'hFFFF_FFFF, 1'b0, 5'd16, 11'd1024);
        1: configure(32'd235929600, 1'b0, 5'd16, 11'd1024);
        2: configure(32'h0, 1'b0, 5'd16, 11'd1024);
        3: configure(32'd1000000, 1'b1, 5'd16, 11'd1024);
        4: configure(32'hFFFF_FFFF, 1'b0, 5'd0, 11'd0);
        5: configure($urandom, 1'b0, 5'($urandom_range(1, 16)), 11'($urandom_range(0, 1024)));
        6: configure(32'hFFFF_FFFF, 1'b1, 5'd31, 11'd2047);
        default: configure(32'h0010_0000, 1'b0, 5'd8, 11'd512);
      endcase
      if (ph == 0) run_directed();
      start = n_items;
      while (n_items - start < 225) begin
        pick = int'($urandom_range(0, 9));
        if (pick < 5) run_group_sequence();
        else if (pick < 7) run_single_sequence();
        else send_item(rand_item());
      end
      drain();
    end
    $display("Sent %0d items over 8 register settings; %0d results, %0d grouped frames.",
             n_items, sb.n_results, sb.n_grouped);
    if (sb.errors == 0 && sb.expq.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
